// File: hdl/mpc_pkg.sv
// Shared types and constants for the media playback clock.
// Holds widths, command codes, rate limits and sequencer state types.
// No dependencies.
`default_nettype none

package mpc_pkg;

    localparam int MAG_W   = 64;
    localparam int HALF_W  = 32;
    localparam int SCALE_W = 40;
    localparam int FREQ_W  = 34;
    localparam int DEN_W   = FREQ_W + 16;
    localparam int PROD_W  = MAG_W + SCALE_W;
    localparam int MUL_W   = HALF_W + SCALE_W;
    localparam int CNT_W   = $clog2(PROD_W);
    localparam int RATE_W  = 20;
    localparam int REQ_W   = 24;
    localparam int CORR_W  = 41;
    localparam int LIM_W   = 40;
    localparam int CMD_W   = 3;

    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RESET      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INVALIDATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESUME     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SET_RATE   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CORRECT    = 3'd6;

    localparam logic [RATE_W-1:0]  RATE_ONE     = 20'd65536;
    localparam logic [RATE_W-1:0]  RATE_MIN     = 20'd6554;
    localparam logic [RATE_W-1:0]  RATE_MAX     = 20'd524288;
    localparam logic [RATE_W-1:0]  US_PER_SEC   = 20'd1000000;
    localparam logic [FREQ_W-1:0]  FREQ_DEFAULT = 34'd1000000;
    localparam logic [SCALE_W-1:0] SCALE_RESET  = 40'd65536000000;
    localparam logic [LIM_W-1:0]   LIM_MAX      = 40'hFF_FFFF_FFFF;
    localparam logic [MAG_W-1:0]   SIGN64       = 64'h8000_0000_0000_0000;
    localparam logic [MAG_W-1:0]   MAX64        = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        SCL_IDLE,
        SCL_MUL_LO,
        SCL_MUL_HI,
        SCL_DIV,
        SCL_RND
    } scl_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_LAUNCH,
        ST_WAIT,
        ST_POS,
        ST_CORR,
        ST_APPLY,
        ST_FIN
    } mpc_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } scl_stat_t;

endpackage

`default_nettype wire

// File: hdl/mpc_scaler.sv
// Iterative scaling unit: elapsed ticks times rate scale, divided by the frequency shifted left by 16 bits.
// Partial-product multiply in low and high halves, bit-serial restoring divide, round and clamp.
// Depends on mpc_pkg.
`default_nettype none

module mpc_scaler (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [mpc_pkg::MAG_W-1:0]     mag,
    input  wire logic [mpc_pkg::SCALE_W-1:0]   scale,
    input  wire logic [mpc_pkg::FREQ_W-1:0]    freq,
    output mpc_pkg::scl_stat_t                 stat,
    output logic      [mpc_pkg::MAG_W-1:0]     quot
);

    mpc_pkg::scl_state_t state_reg, state_next;

    logic [mpc_pkg::MAG_W-1:0]   mag_reg;
    logic [mpc_pkg::SCALE_W-1:0] scale_reg;
    logic [mpc_pkg::DEN_W-1:0]   den_reg;
    logic [mpc_pkg::PROD_W-1:0]  prod_reg;
    logic [mpc_pkg::DEN_W-1:0]   rem_reg;
    logic [mpc_pkg::CNT_W-1:0]   cnt_reg;
    logic [mpc_pkg::MAG_W-1:0]   quot_reg;

    logic [mpc_pkg::HALF_W-1:0]  mul_a;
    logic [mpc_pkg::MUL_W-1:0]   mul_p;
    logic [mpc_pkg::DEN_W:0]     r_sh;
    logic [mpc_pkg::DEN_W:0]     r_diff;
    logic                        q_bit;
    logic                        rnd_up;
    logic [mpc_pkg::PROD_W:0]    q_rnd;
    logic                        q_sat;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mpc_pkg::SCL_IDLE:   if (start) state_next = mpc_pkg::SCL_MUL_LO;
            mpc_pkg::SCL_MUL_LO: state_next = mpc_pkg::SCL_MUL_HI;
            mpc_pkg::SCL_MUL_HI: state_next = mpc_pkg::SCL_DIV;
            mpc_pkg::SCL_DIV: begin
                if (cnt_reg == mpc_pkg::CNT_W'(mpc_pkg::PROD_W - 1)) begin
                    state_next = mpc_pkg::SCL_RND;
                end
            end
            mpc_pkg::SCL_RND:    state_next = mpc_pkg::SCL_IDLE;
            default:             state_next = mpc_pkg::SCL_IDLE;
        endcase
    end

    always_comb begin
        stat.busy = (state_reg != mpc_pkg::SCL_IDLE);
        stat.done = (state_reg == mpc_pkg::SCL_RND);
    end

    assign quot = quot_reg;

    always_comb begin
        mul_a  = (state_reg == mpc_pkg::SCL_MUL_HI) ? mag_reg[mpc_pkg::MAG_W-1:mpc_pkg::HALF_W]
                                                    : mag_reg[mpc_pkg::HALF_W-1:0];
        mul_p  = mpc_pkg::MUL_W'(mul_a) * mpc_pkg::MUL_W'(scale_reg);
        r_sh   = {rem_reg, prod_reg[mpc_pkg::PROD_W-1]};
        q_bit  = (r_sh >= {1'b0, den_reg});
        r_diff = r_sh - {1'b0, den_reg};
        rnd_up = ({rem_reg, 1'b0} >= {1'b0, den_reg});
        q_rnd  = {1'b0, prod_reg} + (mpc_pkg::PROD_W + 1)'(rnd_up);
        q_sat  = (|q_rnd[mpc_pkg::PROD_W:mpc_pkg::MAG_W])
                 || (q_rnd[mpc_pkg::MAG_W-1:0] > mpc_pkg::SIGN64);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mpc_pkg::SCL_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == mpc_pkg::SCL_MUL_HI) begin
                cnt_reg <= '0;
            end else if (state_reg == mpc_pkg::SCL_DIV) begin
                cnt_reg <= cnt_reg + mpc_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            mpc_pkg::SCL_IDLE: begin
                if (start) begin
                    mag_reg   <= mag;
                    scale_reg <= scale;
                    den_reg   <= {freq, {(mpc_pkg::DEN_W - mpc_pkg::FREQ_W){1'b0}}};
                end
            end
            mpc_pkg::SCL_MUL_LO: begin
                prod_reg <= mpc_pkg::PROD_W'(mul_p);
            end
            mpc_pkg::SCL_MUL_HI: begin
                prod_reg <= prod_reg + {mul_p, {mpc_pkg::HALF_W{1'b0}}};
                rem_reg  <= '0;
            end
            mpc_pkg::SCL_DIV: begin
                rem_reg  <= q_bit ? r_diff[mpc_pkg::DEN_W-1:0] : r_sh[mpc_pkg::DEN_W-1:0];
                prod_reg <= {prod_reg[mpc_pkg::PROD_W-2:0], q_bit};
            end
            mpc_pkg::SCL_RND: begin
                quot_reg <= q_sat ? mpc_pkg::SIGN64 : q_rnd[mpc_pkg::MAG_W-1:0];
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/media_playback_clock.sv
// The running position goes through mpc_scaler when the clock is valid and not paused, for
// every command but reset and invalidate; otherwise the divider is skipped.
// Commands are taken one at a time, each may wait on the 104-step bit-serial divider
// in mpc_scaler; the next transfer is taken once the result sits in the output register.
// Reset: synchronous, active low; clears epoch, flags and output valid, rate to one,
// counter frequency to 1000000.
`default_nettype none

module media_playback_clock (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [mpc_pkg::FREQ_W-1:0]    cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [mpc_pkg::CMD_W-1:0]     s_command,
    input  wire logic [mpc_pkg::MAG_W-1:0]     s_counter_now,
    input  wire logic [mpc_pkg::MAG_W-1:0]     s_media_time,
    input  wire logic [mpc_pkg::REQ_W-1:0]     s_new_rate,
    input  wire logic [mpc_pkg::CORR_W-1:0]    s_max_correction,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [mpc_pkg::MAG_W-1:0]     m_position,
    output logic      [mpc_pkg::CORR_W-1:0]    m_applied_correction,
    output logic                               m_is_paused,
    output logic                               m_is_valid,
    output logic      [mpc_pkg::RATE_W-1:0]    m_rate_now
);

    function automatic logic [mpc_pkg::MAG_W-1:0] sat_add(
        input logic [mpc_pkg::MAG_W-1:0] e,
        input logic                      neg,
        input logic [mpc_pkg::MAG_W-1:0] mag
    );
        logic [mpc_pkg::MAG_W-1:0] room;
        logic [mpc_pkg::MAG_W-1:0] r;
        if (!neg) begin
            room = mpc_pkg::MAX64 - e;
            if (!e[mpc_pkg::MAG_W-1] && (mag > room)) r = mpc_pkg::MAX64;
            else r = e + mag;
        end else begin
            room = e ^ mpc_pkg::SIGN64;
            if (e[mpc_pkg::MAG_W-1] && (mag > room)) r = mpc_pkg::SIGN64;
            else r = e - mag;
        end
        return r;
    endfunction

    mpc_pkg::mpc_state_t state_reg, state_next;
    mpc_pkg::scl_stat_t  scl_stat;

    logic [mpc_pkg::FREQ_W-1:0]  freq_reg;
    logic [mpc_pkg::FREQ_W-1:0]  freq_eff;

    logic [mpc_pkg::MAG_W-1:0]   epoch_media_reg, epoch_media_next;
    logic [mpc_pkg::MAG_W-1:0]   epoch_count_reg, epoch_count_next;
    logic [mpc_pkg::MAG_W-1:0]   frozen_media_reg, frozen_media_next;
    logic                        paused_reg, paused_next;
    logic                        valid_reg, valid_next;
    logic [mpc_pkg::RATE_W-1:0]  speed_reg, speed_next;
    logic [mpc_pkg::SCALE_W-1:0] scale_reg, scale_next;

    logic [mpc_pkg::CMD_W-1:0]   cmd_reg;
    logic [mpc_pkg::MAG_W-1:0]   now_reg;
    logic [mpc_pkg::MAG_W-1:0]   media_reg;
    logic [mpc_pkg::REQ_W-1:0]   req_reg;
    logic [mpc_pkg::CORR_W-1:0]  maxc_reg;

    logic                        run_neg_reg;
    logic [mpc_pkg::MAG_W-1:0]   run_mag_reg;
    logic [mpc_pkg::MAG_W-1:0]   cur_reg;
    logic                        corr_neg_reg;
    logic [mpc_pkg::LIM_W-1:0]   corr_mag_reg;
    logic [mpc_pkg::MAG_W-1:0]   out_pos_reg, out_pos_next;
    logic [mpc_pkg::CORR_W-1:0]  applied_reg, applied_next;
    logic                        fin_run_reg, fin_run_next;

    logic                        m_valid_reg;
    logic [mpc_pkg::MAG_W-1:0]   m_position_reg;
    logic [mpc_pkg::CORR_W-1:0]  m_applied_reg;
    logic                        m_paused_reg;
    logic                        m_isvalid_reg;
    logic [mpc_pkg::RATE_W-1:0]  m_rate_reg;

    logic                        need_div;
    logic                        scl_start;
    logic                        out_load;
    logic [mpc_pkg::MAG_W-1:0]   quot;

    logic                        run_neg;
    logic [mpc_pkg::MAG_W-1:0]   run_mag;
    logic [mpc_pkg::MAG_W-1:0]   cur_next;
    logic                        corr_neg;
    logic [mpc_pkg::MAG_W-1:0]   corr_err;
    logic [mpc_pkg::CORR_W-1:0]  lim_abs;
    logic [mpc_pkg::LIM_W-1:0]   lim;
    logic [mpc_pkg::LIM_W-1:0]   corr_mag;
    logic [mpc_pkg::RATE_W-1:0]  rate_clamped;
    logic [mpc_pkg::MAG_W-1:0]   corr_sum;
    logic [mpc_pkg::MAG_W-1:0]   fin_pos;

    mpc_scaler u_scaler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scl_start),
        .mag     (run_mag_reg),
        .scale   (scale_reg),
        .freq    (freq_eff),
        .stat    (scl_stat),
        .quot    (quot)
    );

    assign freq_eff = (freq_reg == '0) ? mpc_pkg::FREQ_DEFAULT : freq_reg;
    assign need_div = valid_reg && !paused_reg && (cmd_reg != mpc_pkg::CMD_RESET)
                      && (cmd_reg != mpc_pkg::CMD_INVALIDATE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mpc_pkg::ST_IDLE:   if (s_valid) state_next = mpc_pkg::ST_PREP;
            mpc_pkg::ST_PREP:   state_next = need_div ? mpc_pkg::ST_LAUNCH : mpc_pkg::ST_POS;
            mpc_pkg::ST_LAUNCH: state_next = mpc_pkg::ST_WAIT;
            mpc_pkg::ST_WAIT:   if (scl_stat.done) state_next = mpc_pkg::ST_POS;
            mpc_pkg::ST_POS:    state_next = mpc_pkg::ST_CORR;
            mpc_pkg::ST_CORR:   state_next = mpc_pkg::ST_APPLY;
            mpc_pkg::ST_APPLY:  state_next = mpc_pkg::ST_FIN;
            mpc_pkg::ST_FIN:    if (!m_valid_reg || m_ready) state_next = mpc_pkg::ST_IDLE;
            default:            state_next = mpc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == mpc_pkg::ST_IDLE);
        scl_start = (state_reg == mpc_pkg::ST_LAUNCH);
        out_load  = (state_reg == mpc_pkg::ST_FIN) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        run_neg  = $signed(now_reg) < $signed(epoch_count_reg);
        run_mag  = run_neg ? (epoch_count_reg - now_reg) : (now_reg - epoch_count_reg);

        if (!valid_reg) cur_next = '0;
        else if (paused_reg) cur_next = frozen_media_reg;
        else cur_next = sat_add(epoch_media_reg, run_neg_reg, quot);

        corr_neg = $signed(media_reg) < $signed(cur_reg);
        corr_err = corr_neg ? (cur_reg - media_reg) : (media_reg - cur_reg);
        lim_abs  = maxc_reg[mpc_pkg::CORR_W-1] ? (~maxc_reg + mpc_pkg::CORR_W'(1)) : maxc_reg;
        lim      = (lim_abs > {1'b0, mpc_pkg::LIM_MAX}) ? mpc_pkg::LIM_MAX
                                                        : lim_abs[mpc_pkg::LIM_W-1:0];
        corr_mag = (corr_err < mpc_pkg::MAG_W'(lim)) ? corr_err[mpc_pkg::LIM_W-1:0] : lim;

        fin_pos  = fin_run_reg ? sat_add(epoch_media_reg, run_neg_reg, quot) : out_pos_reg;
    end

    always_comb begin
        epoch_media_next  = epoch_media_reg;
        epoch_count_next  = epoch_count_reg;
        frozen_media_next = frozen_media_reg;
        paused_next       = paused_reg;
        valid_next        = valid_reg;
        speed_next        = speed_reg;
        scale_next        = scale_reg;
        out_pos_next      = cur_reg;
        applied_next      = '0;
        fin_run_next      = 1'b0;

        if (req_reg < mpc_pkg::REQ_W'(mpc_pkg::RATE_MIN)) rate_clamped = mpc_pkg::RATE_MIN;
        else if (req_reg > mpc_pkg::REQ_W'(mpc_pkg::RATE_MAX)) rate_clamped = mpc_pkg::RATE_MAX;
        else rate_clamped = req_reg[mpc_pkg::RATE_W-1:0];

        corr_sum = sat_add(paused_reg ? frozen_media_reg : epoch_media_reg, corr_neg_reg,
                           mpc_pkg::MAG_W'(corr_mag_reg));

        unique case (cmd_reg)
            mpc_pkg::CMD_RESET: begin
                epoch_media_next  = media_reg;
                epoch_count_next  = now_reg;
                frozen_media_next = media_reg;
                paused_next       = 1'b0;
                valid_next        = 1'b1;
                out_pos_next      = media_reg;
            end
            mpc_pkg::CMD_INVALIDATE: begin
                epoch_media_next  = '0;
                epoch_count_next  = '0;
                frozen_media_next = '0;
                paused_next       = 1'b0;
                valid_next        = 1'b0;
                out_pos_next      = '0;
            end
            mpc_pkg::CMD_PAUSE: begin
                if (valid_reg && !paused_reg) begin
                    frozen_media_next = cur_reg;
                    paused_next       = 1'b1;
                end
            end
            mpc_pkg::CMD_RESUME: begin
                if (valid_reg && paused_reg) begin
                    epoch_media_next = frozen_media_reg;
                    epoch_count_next = now_reg;
                    paused_next      = 1'b0;
                end
            end
            mpc_pkg::CMD_SET_RATE: begin
                speed_next = rate_clamped;
                scale_next = mpc_pkg::SCALE_W'(rate_clamped) * mpc_pkg::SCALE_W'(mpc_pkg::US_PER_SEC);
                if (paused_reg) begin
                    frozen_media_next = cur_reg;
                end else begin
                    epoch_media_next = cur_reg;
                    epoch_count_next = now_reg;
                end
            end
            mpc_pkg::CMD_CORRECT: begin
                if (valid_reg) begin
                    applied_next = corr_neg_reg ? (~mpc_pkg::CORR_W'(corr_mag_reg) + mpc_pkg::CORR_W'(1))
                                                : mpc_pkg::CORR_W'(corr_mag_reg);
                    if (paused_reg) begin
                        frozen_media_next = corr_sum;
                        out_pos_next      = corr_sum;
                    end else begin
                        epoch_media_next = corr_sum;
                        fin_run_next     = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= mpc_pkg::ST_IDLE;
            freq_reg         <= mpc_pkg::FREQ_DEFAULT;
            epoch_media_reg  <= '0;
            epoch_count_reg  <= '0;
            frozen_media_reg <= '0;
            paused_reg       <= 1'b0;
            valid_reg        <= 1'b0;
            speed_reg        <= mpc_pkg::RATE_ONE;
            scale_reg        <= mpc_pkg::SCALE_RESET;
            fin_run_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                freq_reg <= cfg_wr_data;
            end
            if (state_reg == mpc_pkg::ST_APPLY) begin
                epoch_media_reg  <= epoch_media_next;
                epoch_count_reg  <= epoch_count_next;
                frozen_media_reg <= frozen_media_next;
                paused_reg       <= paused_next;
                valid_reg        <= valid_next;
                speed_reg        <= speed_next;
                scale_reg        <= scale_next;
                fin_run_reg      <= fin_run_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_command;
            now_reg   <= s_counter_now;
            media_reg <= s_media_time;
            req_reg   <= s_new_rate;
            maxc_reg  <= s_max_correction;
        end
        if (state_reg == mpc_pkg::ST_PREP) begin
            run_neg_reg <= run_neg;
            run_mag_reg <= run_mag;
        end
        if (state_reg == mpc_pkg::ST_POS) begin
            cur_reg <= cur_next;
        end
        if (state_reg == mpc_pkg::ST_CORR) begin
            corr_neg_reg <= corr_neg;
            corr_mag_reg <= corr_mag;
        end
        if (state_reg == mpc_pkg::ST_APPLY) begin
            out_pos_reg <= out_pos_next;
            applied_reg <= applied_next;
        end
        if (out_load) begin
            m_position_reg <= fin_pos;
            m_applied_reg  <= applied_reg;
            m_paused_reg   <= paused_reg;
            m_isvalid_reg  <= valid_reg;
            m_rate_reg     <= speed_reg;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_position           = m_position_reg;
    assign m_applied_correction = m_applied_reg;
    assign m_is_paused          = m_paused_reg;
    assign m_is_valid           = m_isvalid_reg;
    assign m_rate_now           = m_rate_reg;

endmodule

`default_nettype wire

// File: hdl/mpc_checker.sv
// Port-level checks for media_playback_clock, attached by bind.
// Depends on mpc_pkg and the top-level port list.
`default_nettype none

module mpc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          cfg_wr_en,
    input wire logic [mpc_pkg::FREQ_W-1:0]    cfg_wr_data,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic [mpc_pkg::CMD_W-1:0]     s_command,
    input wire logic [mpc_pkg::MAG_W-1:0]     s_counter_now,
    input wire logic [mpc_pkg::MAG_W-1:0]     s_media_time,
    input wire logic [mpc_pkg::REQ_W-1:0]     s_new_rate,
    input wire logic [mpc_pkg::CORR_W-1:0]    s_max_correction,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [mpc_pkg::MAG_W-1:0]     m_position,
    input wire logic [mpc_pkg::CORR_W-1:0]    m_applied_correction,
    input wire logic                          m_is_paused,
    input wire logic                          m_is_valid,
    input wire logic [mpc_pkg::RATE_W-1:0]    m_rate_now
);

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer taken while a command is in work");

    a_invalid_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_valid |-> (m_position == '0) && !m_is_paused
                                   && (m_applied_correction == '0))
        else $error("invalid clock reports nonzero position or correction");

    a_rate_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rate_now >= mpc_pkg::RATE_MIN) && (m_rate_now <= mpc_pkg::RATE_MAX))
        else $error("rate outside clamp range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position) && $stable(m_rate_now))
        else $error("stalled result changed");

endmodule

bind media_playback_clock mpc_checker u_mpc_checker (.*);

`default_nettype wire

// File: test/media_playback_clock_tb.sv
// Testbench for media_playback_clock: command traffic with random handshake gaps, each result
// checked against an in-bench model of the epoch, pause, rate and correction arithmetic.
// Depends on mpc_pkg and media_playback_clock.
`default_nettype none

module media_playback_clock_tb;

    import mpc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
    localparam int unsigned IDLE_PCT    = 27;
    localparam int          HOLD_CYCLES = 400;
    localparam int          TAIL_CYCLES = 120;

    typedef struct packed {
        logic [MAG_W-1:0]  position;
        logic [CORR_W-1:0] correction;
        logic              paused;
        logic              valid;
        logic [RATE_W-1:0] rate;
    } clock_reading_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [FREQ_W-1:0]   cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command;
    logic [MAG_W-1:0]    s_counter_now;
    logic [MAG_W-1:0]    s_media_time;
    logic [REQ_W-1:0]    s_new_rate;
    logic [CORR_W-1:0]   s_max_correction;
    logic                m_valid;
    logic                m_ready;
    logic [MAG_W-1:0]    m_position;
    logic [CORR_W-1:0]   m_applied_correction;
    logic                m_is_paused;
    logic                m_is_valid;
    logic [RATE_W-1:0]   m_rate_now;

    logic [FREQ_W-1:0]   tick_rate    = FREQ_DEFAULT;
    logic [MAG_W-1:0]    anchor_media = '0;
    logic [MAG_W-1:0]    anchor_ticks = '0;
    logic [MAG_W-1:0]    frozen_time  = '0;
    logic                is_held      = 1'b0;
    logic                is_locked    = 1'b0;
    logic [RATE_W-1:0]   play_rate    = RATE_ONE;

    clock_reading_t      expected_readings[$];
    clock_reading_t      head_reading;
    int unsigned         idle_pct = IDLE_PCT;
    logic                hold_req = 1'b0;
    int                  stall_count;
    int                  fault_count = 0;
    int                  results_checked = 0;
    int                  rate_writes = 0;
    int                  command_tally[8] = '{default: 0};

    media_playback_clock dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_command            (s_command),
        .s_counter_now        (s_counter_now),
        .s_media_time         (s_media_time),
        .s_new_rate           (s_new_rate),
        .s_max_correction     (s_max_correction),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_position           (m_position),
        .m_applied_correction (m_applied_correction),
        .m_is_paused          (m_is_paused),
        .m_is_valid           (m_is_valid),
        .m_rate_now           (m_rate_now)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [MAG_W-1:0] saturating_shift(logic [MAG_W-1:0] base, logic down,
                                                          logic [MAG_W-1:0] amount);
        logic signed [MAG_W+1:0] total;
        total = $signed({{2{base[MAG_W-1]}}, base});
        if (down) begin
            total = total - $signed({2'b00, amount});
        end else begin
            total = total + $signed({2'b00, amount});
        end
        if (total > $signed({2'b00, MAX64})) return MAX64;
        if (total < -$signed({2'b00, SIGN64})) return SIGN64;
        return total[MAG_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] running_time(logic [MAG_W-1:0] ticks);
        logic              down;
        logic [MAG_W-1:0]  span;
        logic [FREQ_W-1:0] freq;
        logic [127:0]      prod;
        logic [127:0]      den;
        logic [127:0]      quo;
        logic [127:0]      rem;
        down = $signed(ticks) < $signed(anchor_ticks);
        span = down ? anchor_ticks - ticks : ticks - anchor_ticks;
        freq = (tick_rate == '0) ? FREQ_DEFAULT : tick_rate;
        den  = {78'd0, freq, 16'd0};
        prod = {64'd0, span} * {108'd0, US_PER_SEC} * {108'd0, play_rate};
        quo  = prod / den;
        rem  = prod % den;
        if (rem >= den - rem) quo = quo + 128'd1;
        if (quo > {64'd0, SIGN64}) quo = {64'd0, SIGN64};
        return saturating_shift(anchor_media, down, quo[MAG_W-1:0]);
    endfunction

    function automatic logic [MAG_W-1:0] clock_position(logic [MAG_W-1:0] ticks);
        if (!is_locked) return '0;
        if (is_held) return frozen_time;
        return running_time(ticks);
    endfunction

    function automatic clock_reading_t advance_clock(logic [CMD_W-1:0] cmd,
                                                     logic [MAG_W-1:0] ticks,
                                                     logic [MAG_W-1:0] media,
                                                     logic [REQ_W-1:0] req,
                                                     logic [CORR_W-1:0] max_corr);
        clock_reading_t    reading;
        logic [MAG_W-1:0]  now_pos;
        logic [MAG_W-1:0]  gap;
        logic [MAG_W-1:0]  step;
        logic [CORR_W-1:0] limit;
        logic              down;
        reading = '0;
        case (cmd)
            CMD_RESET: begin
                anchor_media = media;
                anchor_ticks = ticks;
                frozen_time  = media;
                is_held      = 1'b0;
                is_locked    = 1'b1;
            end
            CMD_INVALIDATE: begin
                anchor_media = '0;
                anchor_ticks = '0;
                frozen_time  = '0;
                is_held      = 1'b0;
                is_locked    = 1'b0;
            end
            CMD_PAUSE: begin
                if (is_locked && !is_held) begin
                    frozen_time = clock_position(ticks);
                    is_held     = 1'b1;
                end
            end
            CMD_RESUME: begin
                if (is_locked && is_held) begin
                    anchor_media = frozen_time;
                    anchor_ticks = ticks;
                    is_held      = 1'b0;
                end
            end
            CMD_SET_RATE: begin
                now_pos = clock_position(ticks);
                if (req < {4'd0, RATE_MIN}) begin
                    play_rate = RATE_MIN;
                end else if (req > {4'd0, RATE_MAX}) begin
                    play_rate = RATE_MAX;
                end else begin
                    play_rate = req[RATE_W-1:0];
                end
                if (is_held) begin
                    frozen_time = now_pos;
                end else begin
                    anchor_media = now_pos;
                    anchor_ticks = ticks;
                end
            end
            CMD_CORRECT: begin
                if (is_locked) begin
                    now_pos = clock_position(ticks);
                    down    = $signed(media) < $signed(now_pos);
                    gap     = down ? now_pos - media : media - now_pos;
                    limit   = max_corr[CORR_W-1] ? -max_corr : max_corr;
                    if (limit > {1'b0, LIM_MAX}) limit = {1'b0, LIM_MAX};
                    step = (gap < {23'd0, limit}) ? gap : {23'd0, limit};
                    if (is_held) begin
                        frozen_time = saturating_shift(frozen_time, down, step);
                    end else begin
                        anchor_media = saturating_shift(anchor_media, down, step);
                    end
                    reading.correction = down ? -step[CORR_W-1:0] : step[CORR_W-1:0];
                end
            end
            default: begin
            end
        endcase
        reading.position = clock_position(ticks);
        reading.paused   = is_held;
        reading.valid    = is_locked;
        reading.rate     = play_rate;
        return reading;
    endfunction

    function automatic logic [MAG_W-1:0] any_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [MAG_W-1:0] media_offset();
        logic [MAG_W-1:0] v;
        case ($urandom_range(0, 9))
            6, 7: v = {32'd0, $urandom()};
            8: v = any_word();
            9: begin
                case ($urandom_range(0, 2))
                    0: v = MAX64;
                    1: v = SIGN64;
                    default: v = '0;
                endcase
            end
            default: v = {32'd0, $urandom_range(0, 32'h10_0000)};
        endcase
        if ($urandom_range(0, 1) == 1) v = -v;
        return v;
    endfunction

    function automatic logic [MAG_W-1:0] tick_step();
        case ($urandom_range(0, 19))
            0: return any_word();
            1, 2: return -{32'd0, $urandom_range(0, 32'h4_0000)};
            3: return {32'd0, $urandom()};
            default: return {32'd0, $urandom_range(0, 32'h3_0000)};
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] rate_pick();
        logic [31:0] r;
        if ($urandom_range(0, 4) != 0) begin
            r = $urandom_range(RATE_MIN, RATE_MAX);
        end else begin
            r = $urandom();
        end
        return r[REQ_W-1:0];
    endfunction

    function automatic logic [CORR_W-1:0] limit_pick();
        logic [MAG_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = any_word();
            1: begin
                case ($urandom_range(0, 2))
                    0: v = {23'd0, 41'h100_0000_0000};
                    1: v = {23'd0, 41'h0FF_FFFF_FFFF};
                    default: v = '1;
                endcase
            end
            default: begin
                v = {32'd0, $urandom_range(0, 32'h1_0000)};
                if ($urandom_range(0, 1) == 1) v = -v;
            end
        endcase
        return v[CORR_W-1:0];
    endfunction

    function automatic logic [CMD_W-1:0] command_pick();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 28) return CMD_QUERY;
        if (p < 38) return CMD_PAUSE;
        if (p < 48) return CMD_RESUME;
        if (p < 63) return CMD_SET_RATE;
        if (p < 85) return CMD_CORRECT;
        if (p < 91) return CMD_RESET;
        if (p < 95) return CMD_INVALIDATE;
        return CMD_SPARE;
    endfunction

    function automatic logic [FREQ_W-1:0] frequency_pick();
        case ($urandom_range(0, 7))
            0: return 34'd48000;
            1: return 34'd90000;
            2: return 34'd27000000;
            3: return 34'd1;
            4: return 34'd10000000000;
            5: return {2'b00, $urandom_range(1, 32'hFFFF_FFFF)};
            default: return FREQ_DEFAULT;
        endcase
    endfunction

    task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [MAG_W-1:0] ticks,
                                 input logic [MAG_W-1:0] media, input logic [REQ_W-1:0] req,
                                 input logic [CORR_W-1:0] max_corr);
        @(negedge aclk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= cmd;
        s_counter_now    <= ticks;
        s_media_time     <= media;
        s_new_rate       <= req;
        s_max_correction <= max_corr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_readings.push_back(advance_clock(cmd, ticks, media, req, max_corr));
        command_tally[cmd]++;
    endtask

    task automatic wait_for_readings();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
    endtask

    task automatic set_tick_rate(input logic [FREQ_W-1:0] freq);
        wait_for_readings();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= freq;
        tick_rate = freq;
        rate_writes++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_session(input int len);
        logic [MAG_W-1:0] ticks;
        logic [MAG_W-1:0] media;
        logic [CMD_W-1:0] cmd;
        int               i;
        ticks = ($urandom_range(0, 3) == 0) ? any_word() : {32'd0, $urandom()};
        offer_command(CMD_RESET, ticks, media_offset(), rate_pick(), limit_pick());
        for (i = 1; i < len; i++) begin
            cmd   = command_pick();
            ticks = ticks + tick_step();
            if (cmd == CMD_CORRECT || cmd == CMD_RESET) begin
                media = clock_position(ticks) + media_offset();
            end else begin
                media = any_word();
            end
            offer_command(cmd, ticks, media, rate_pick(), limit_pick());
        end
    endtask

    task automatic test_unlocked_clock();
        offer_command(CMD_QUERY, any_word(), any_word(), rate_pick(), limit_pick());
        offer_command(CMD_SPARE, MAX64, any_word(), rate_pick(), limit_pick());
        offer_command(CMD_PAUSE, any_word(), any_word(), rate_pick(), limit_pick());
        offer_command(CMD_RESUME, any_word(), any_word(), rate_pick(), limit_pick());
        offer_command(CMD_CORRECT, 64'd0, MAX64, rate_pick(), 41'h100_0000_0000);
        offer_command(CMD_SET_RATE, any_word(), any_word(), 24'hFF_FFFF, limit_pick());
        offer_command(CMD_SET_RATE, any_word(), any_word(), 24'h00_0000, limit_pick());
        offer_command(CMD_SET_RATE, 64'd0, any_word(), {4'd0, RATE_ONE}, limit_pick());
        offer_command(CMD_INVALIDATE, any_word(), any_word(), rate_pick(), limit_pick());
    endtask

    task automatic test_extremes();
        offer_command(CMD_RESET, SIGN64, 64'd0, rate_pick(), limit_pick());
        offer_command(CMD_QUERY, MAX64, any_word(), rate_pick(), limit_pick());
        offer_command(CMD_RESET, MAX64, 64'd0, rate_pick(), limit_pick());
        offer_command(CMD_QUERY, SIGN64, any_word(), rate_pick(), limit_pick());
        offer_command(CMD_RESET, 64'd1000, MAX64 - 64'd5, rate_pick(), limit_pick());
        offer_command(CMD_CORRECT, 64'd900, MAX64, rate_pick(), 41'd1000);
        offer_command(CMD_RESET, 64'd1000, SIGN64 + 64'd5, rate_pick(), limit_pick());
        offer_command(CMD_CORRECT, 64'd1100, SIGN64, rate_pick(), -41'd1000);
        offer_command(CMD_CORRECT, 64'd5000, MAX64, rate_pick(), 41'h100_0000_0000);
        offer_command(CMD_CORRECT, 64'd5000, SIGN64, rate_pick(), 41'h0FF_FFFF_FFFF);
        offer_command(CMD_CORRECT, 64'd5000, 64'd12345, rate_pick(), 41'd0);
        offer_command(CMD_SET_RATE, 64'd6000, any_word(), 24'd6553, limit_pick());
        offer_command(CMD_SET_RATE, 64'd7000, any_word(), 24'd524289, limit_pick());
        offer_command(CMD_PAUSE, 64'd8000, any_word(), rate_pick(), limit_pick());
        offer_command(CMD_QUERY, 64'd90000, any_word(), rate_pick(), limit_pick());
        offer_command(CMD_SET_RATE, 64'd95000, any_word(), {4'd0, RATE_MIN}, limit_pick());
        offer_command(CMD_CORRECT, 64'd96000, 64'd0, rate_pick(), 41'd50);
        offer_command(CMD_PAUSE, 64'd97000, any_word(), rate_pick(), limit_pick());
        offer_command(CMD_RESUME, 64'd100000, any_word(), rate_pick(), limit_pick());
        offer_command(CMD_SET_RATE, 64'd100500, any_word(), {4'd0, RATE_ONE}, limit_pick());
        offer_command(CMD_QUERY, SIGN64, any_word(), rate_pick(), limit_pick());
        offer_command(CMD_INVALIDATE, 64'd0, any_word(), rate_pick(), limit_pick());
    endtask

    task automatic test_frequency_sweep();
        logic [FREQ_W-1:0] sweep[7];
        logic [MAG_W-1:0]  base;
        int                k;
        sweep = '{34'd1, 34'd0, 34'd10000000000, 34'h3_FFFF_FFFF, 34'd2000000, 34'd48000,
                  FREQ_DEFAULT};
        for (k = 0; k < 7; k++) begin
            set_tick_rate(sweep[k]);
            base = {32'd0, $urandom()};
            offer_command(CMD_RESET, base, media_offset(), rate_pick(), limit_pick());
            offer_command(CMD_QUERY, base + 64'd1, any_word(), rate_pick(), limit_pick());
            offer_command(CMD_QUERY, base - 64'd3, any_word(), rate_pick(), limit_pick());
        end
    endtask

    task automatic test_random_traffic(input int total);
        int sent;
        int len;
        sent = 0;
        while (sent < total) begin
            if (sent != 0 && $urandom_range(0, 3) == 0) set_tick_rate(frequency_pick());
            len = $urandom_range(5, 40);
            run_session(len);
            sent += len;
        end
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        run_session(70);
        idle_pct = IDLE_PCT;
    endtask

    task automatic test_output_stall();
        wait_for_readings();
        hold_req = 1'b1;
        run_session(8);
        wait_for_readings();
    endtask

    task automatic check_field(input string field, input logic [MAG_W-1:0] want,
                               input logic [MAG_W-1:0] got);
        if (want !== got) begin
            fault_count++;
            if (fault_count <= 10) begin
                $display("%s mismatch on result %0d: expected %h, got %h",
                         field, results_checked, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_readings.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("result %0d with nothing pending: position %h",
                             results_checked, m_position);
                end
            end else begin
                head_reading = expected_readings.pop_front();
                check_field("position", head_reading.position, m_position);
                check_field("applied_correction", {23'd0, head_reading.correction},
                            {23'd0, m_applied_correction});
                check_field("is_paused", {63'd0, head_reading.paused}, {63'd0, m_is_paused});
                check_field("is_valid", {63'd0, head_reading.valid}, {63'd0, m_is_valid});
                check_field("rate_now", {44'd0, head_reading.rate}, {44'd0, m_rate_now});
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                for (stall_count = 0; stall_count < HOLD_CYCLES; stall_count++) begin
                    @(negedge aclk);
                end
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    initial begin
        #10000000;
        $display("watchdog expired with %0d results outstanding", expected_readings.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = FREQ_DEFAULT;
        s_valid          = 1'b0;
        s_command        = CMD_QUERY;
        s_counter_now    = '0;
        s_media_time     = '0;
        s_new_rate       = '0;
        s_max_correction = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_unlocked_clock();
        test_extremes();
        test_frequency_sweep();
        test_random_traffic(620);
        test_back_to_back();
        test_output_stall();

        wait_for_readings();
        repeat (TAIL_CYCLES) @(posedge aclk);
        fault_count += expected_readings.size();

        $display("sent %0d transfers: query %0d, epoch %0d, invalidate %0d, pause %0d, %s",
                 results_checked, command_tally[CMD_QUERY], command_tally[CMD_RESET],
                 command_tally[CMD_INVALIDATE], command_tally[CMD_PAUSE],
                 $sformatf("resume %0d, rate %0d, correct %0d, spare code %0d",
                           command_tally[CMD_RESUME], command_tally[CMD_SET_RATE],
                           command_tally[CMD_CORRECT], command_tally[CMD_SPARE]));
        $display("%0d counter frequency writes, %0d faults", rate_writes, fault_count);
        if (fault_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
